// ----- rtl/core/pte_pkg.sv -----
// Shared types and constants for the pedal threshold edge detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pte_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int REG_BITS              = 16;
  localparam int FRAC_BITS             = 16;
  localparam int CFG_INDEX_BITS        = 2;
  localparam int EVENT_BITS            = 2;
  localparam int PEDAL_COUNT           = 3;
  localparam int EVENT_VEC_BITS        = EVENT_BITS * PEDAL_COUNT;

  localparam int PEDAL_SUSTAIN   = 0;
  localparam int PEDAL_SOSTENUTO = 1;
  localparam int PEDAL_SOFT      = 2;

  localparam logic [REG_BITS-1:0] RESET_FRACTION = REG_BITS'(32768);
  localparam logic [REG_BITS-1:0] RESET_INITIAL  = REG_BITS'(13107);

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD_FRACTION = 2'd0,
    CFG_INITIAL_THRESHOLD  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic                 due;
    logic                 update;
    logic [REG_BITS-1:0]  fraction;
    logic [REG_BITS-1:0]  initial_thr;
  } pte_ctrl_t;

endpackage

// ----- rtl/core/pte_pedal.sv -----
// One pedal: connection, calibration, maximum and threshold state plus
// the press/release classifier. Depends on pte_pkg.
`timescale 1ns / 1ps

module pte_pedal #(
  parameter int POSITION_BITS = pte_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pte_pkg::pte_ctrl_t                  ctrl,
  input  logic [POSITION_BITS-1:0]            pos,
  output logic [pte_pkg::EVENT_BITS-1:0]      event_code
);
  import pte_pkg::*;

  localparam int THR_BITS  = (POSITION_BITS > REG_BITS) ? POSITION_BITS : REG_BITS;
  localparam int PROD_BITS = POSITION_BITS + FRAC_BITS;

  logic [POSITION_BITS-1:0] previous_position;
  logic                     pedal_connected;
  logic                     calibrated;
  logic [POSITION_BITS-1:0] max_position;
  logic [THR_BITS-1:0]      active_threshold;

  logic [THR_BITS-1:0]      pos_w;
  logic [THR_BITS-1:0]      prev_w;
  logic [THR_BITS-1:0]      init_w;
  ev_t                      raw_ev;
  ev_t                      ev;
  logic                     connected_next;
  logic                     calibrated_next;
  logic [POSITION_BITS-1:0] max_next;
  logic [PROD_BITS-1:0]     product;
  logic [THR_BITS-1:0]      threshold_next;

  always_comb begin
    pos_w  = THR_BITS'(pos);
    prev_w = THR_BITS'(previous_position);
    init_w = THR_BITS'(ctrl.initial_thr);

    if (pos_w > active_threshold) begin
      raw_ev = (prev_w < active_threshold) ? EV_PRESS : EV_NONE;
    end else begin
      raw_ev = (prev_w > active_threshold) ? EV_RELEASE : EV_NONE;
    end

    connected_next  = pedal_connected || (pos_w < init_w);
    ev              = connected_next ? raw_ev : EV_NONE;
    calibrated_next = calibrated || (ev == EV_PRESS);
    max_next        = (pos > max_position) ? pos : max_position;
    product         = PROD_BITS'(max_next) * PROD_BITS'(ctrl.fraction);
    threshold_next  = calibrated_next ? THR_BITS'(product[PROD_BITS-1:FRAC_BITS]) : init_w;
  end

  assign event_code = ctrl.due ? ev : EV_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_position <= '0;
      pedal_connected   <= 1'b0;
      calibrated        <= 1'b0;
      max_position      <= '0;
      active_threshold  <= THR_BITS'(RESET_INITIAL);
    end else if (ctrl.update) begin
      previous_position <= pos;
      pedal_connected   <= connected_next;
      calibrated        <= calibrated_next;
      active_threshold  <= threshold_next;
      if (calibrated_next) begin
        max_position <= max_next;
      end
    end
  end

endmodule

// ----- rtl/core/pte_out_buf.sv -----
// Two-entry result buffer: visible output register plus skid register.
// Depends on pte_pkg for the default width.
`timescale 1ns / 1ps

module pte_out_buf #(
  parameter int DATA_BITS = pte_pkg::EVENT_VEC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_BITS-1:0] out_data
);
  import pte_pkg::*;

  logic                 skid_valid;
  logic [DATA_BITS-1:0] skid_data;
  logic                 pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (push) begin
        skid_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/core/pedal_threshold_edge_detector.sv -----
// Top level of the pedal threshold edge detector: input register,
// configuration registers, three pedal units and the result buffer.
// Depends on pte_pkg, pte_pedal and pte_out_buf.
//
// Usage:
//   Input channel: in_valid/in_stall carry sample_due and three pedal
//   positions. Output channel: out_valid/out_stall carry one event per
//   pedal (0 no change, 1 pressed, 2 released) for every input item.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 threshold fraction, 1 initial threshold); other indexes are ignored.
//   Write configuration only while the block holds no item.
//   An accepted item is held in the input register and then in the result
//   buffer before it can be taken. Throughput: one item per cycle while
//   out_stall is low; each item passes once through the input register,
//   the per-pedal compare and one 16-bit multiply, into the result register.
//   Reset: clears all pedal state (not connected, not calibrated, maximum
//   zero, threshold at the initial value) and loads register defaults.
//   Stall: a two-entry result buffer absorbs one extra item; in_stall
//   rises only when both entries are full and an item waits in the input
//   register.
`timescale 1ns / 1ps

module pedal_threshold_edge_detector #(
  parameter int POSITION_BITS = pte_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 sample_due,
  input  logic [POSITION_BITS-1:0]             position_sustain,
  input  logic [POSITION_BITS-1:0]             position_sostenuto,
  input  logic [POSITION_BITS-1:0]             position_soft_pedal,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pte_pkg::EVENT_BITS-1:0]       event_sustain,
  output logic [pte_pkg::EVENT_BITS-1:0]       event_sostenuto,
  output logic [pte_pkg::EVENT_BITS-1:0]       event_soft_pedal,
  input  logic                                 cfg_we,
  input  logic [pte_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pte_pkg::REG_BITS-1:0]         cfg_data
);
  import pte_pkg::*;

  logic [REG_BITS-1:0]       threshold_fraction;
  logic [REG_BITS-1:0]       initial_threshold;

  logic                      s1_valid;
  logic                      s1_due;
  logic [POSITION_BITS-1:0]  s1_pos [PEDAL_COUNT];

  logic                      accept;
  logic                      push;
  logic                      obuf_full;
  pte_ctrl_t                 ctrl;
  logic [EVENT_VEC_BITS-1:0] ev_vec;
  logic [EVENT_VEC_BITS-1:0] out_data;

  assign in_stall = s1_valid && obuf_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid && !obuf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_fraction <= RESET_FRACTION;
      initial_threshold  <= RESET_INITIAL;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD_FRACTION: threshold_fraction <= cfg_data;
        CFG_INITIAL_THRESHOLD:  initial_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_due                  <= sample_due;
      s1_pos[PEDAL_SUSTAIN]   <= position_sustain;
      s1_pos[PEDAL_SOSTENUTO] <= position_sostenuto;
      s1_pos[PEDAL_SOFT]      <= position_soft_pedal;
    end
  end

  assign ctrl = '{due:         s1_due,
                  update:      push && s1_due,
                  fraction:    threshold_fraction,
                  initial_thr: initial_threshold};

  for (genvar p = 0; p < PEDAL_COUNT; p++) begin : g_pedal
    pte_pedal #(
      .POSITION_BITS(POSITION_BITS)
    ) u_pedal (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (s1_pos[p]),
      .event_code (ev_vec[p*EVENT_BITS +: EVENT_BITS])
    );
  end

  pte_out_buf #(
    .DATA_BITS(EVENT_VEC_BITS)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (ev_vec),
    .full      (obuf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign event_sustain    = out_data[PEDAL_SUSTAIN*EVENT_BITS +: EVENT_BITS];
  assign event_sostenuto  = out_data[PEDAL_SOSTENUTO*EVENT_BITS +: EVENT_BITS];
  assign event_soft_pedal = out_data[PEDAL_SOFT*EVENT_BITS +: EVENT_BITS];

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_event_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_sustain != 2'b11) && (event_sostenuto != 2'b11) &&
                  (event_soft_pedal != 2'b11))
    else $error("illegal event code on output");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !s1_valid && !obuf_full |=> !out_valid)
    else $error("result repeated after it was taken");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("channels not idle after reset");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for pedal_threshold_edge_detector: a queue-fed driver,
// a stalling monitor and a per-pedal event predictor checked in order.
// Depends on pte_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import pte_pkg::*;

  localparam int PB = POSITION_BITS_DEFAULT;
  localparam int LATENCY_SLACK = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic          due;
    logic [PB-1:0] sustain;
    logic [PB-1:0] sostenuto;
    logic [PB-1:0] soft_pedal;
  } sample_t;

  typedef struct packed {
    ev_t sustain;
    ev_t sostenuto;
    ev_t soft_pedal;
  } events_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic sample_due = 1'b0;
  logic [PB-1:0] position_sustain = '0;
  logic [PB-1:0] position_sostenuto = '0;
  logic [PB-1:0] position_soft_pedal = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EVENT_BITS-1:0] event_sustain;
  logic [EVENT_BITS-1:0] event_sostenuto;
  logic [EVENT_BITS-1:0] event_soft_pedal;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;

  pedal_threshold_edge_detector #(.POSITION_BITS(PB)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_due(sample_due),
    .position_sustain(position_sustain),
    .position_sostenuto(position_sostenuto),
    .position_soft_pedal(position_soft_pedal),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_sustain(event_sustain),
    .event_sostenuto(event_sostenuto),
    .event_soft_pedal(event_soft_pedal),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  sample_t sample_q[$];
  events_t pending_events[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  // predictor copy of the registers and the per-pedal state
  logic [REG_BITS-1:0] frac_q = RESET_FRACTION;
  logic [REG_BITS-1:0] init_q = RESET_INITIAL;
  logic [PB-1:0] last_pos [PEDAL_COUNT] = '{default: '0};
  logic          linked   [PEDAL_COUNT] = '{default: 1'b0};
  logic          calib    [PEDAL_COUNT] = '{default: 1'b0};
  logic [PB-1:0] peak     [PEDAL_COUNT] = '{default: '0};
  logic [PB-1:0] level    [PEDAL_COUNT] = '{default: RESET_INITIAL};
  int walk [PEDAL_COUNT] = '{default: 0};

  function automatic ev_t crossing(logic [PB-1:0] now, logic [PB-1:0] was,
                                   logic [PB-1:0] thr);
    if (now > thr) return (was < thr) ? EV_PRESS : EV_NONE;
    return (was > thr) ? EV_RELEASE : EV_NONE;
  endfunction

  task automatic predict_events(input sample_t s);
    ev_t ev [PEDAL_COUNT];
    logic [PB-1:0] pos [PEDAL_COUNT];
    logic [31:0] prod;
    events_t e;
    pos[PEDAL_SUSTAIN] = s.sustain;
    pos[PEDAL_SOSTENUTO] = s.sostenuto;
    pos[PEDAL_SOFT] = s.soft_pedal;
    for (int p = 0; p < PEDAL_COUNT; p++) begin
      ev[p] = EV_NONE;
      if (s.due) begin
        ev[p] = crossing(pos[p], last_pos[p], level[p]);
        last_pos[p] = pos[p];
        if (pos[p] < init_q) linked[p] = 1'b1;
        if (!linked[p]) ev[p] = EV_NONE;
        if (ev[p] == EV_PRESS) calib[p] = 1'b1;
        if (calib[p]) begin
          if (pos[p] > peak[p]) peak[p] = pos[p];
          prod = peak[p] * frac_q;
          level[p] = prod[31:16];
        end else begin
          level[p] = init_q;
        end
      end
    end
    e.sustain = ev[PEDAL_SUSTAIN];
    e.sostenuto = ev[PEDAL_SOSTENUTO];
    e.soft_pedal = ev[PEDAL_SOFT];
    pending_events.push_back(e);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_events('{sample_due, position_sustain, position_sostenuto,
                         position_soft_pedal});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_t s;
          s = sample_q.pop_front();
          in_valid <= 1'b1;
          sample_due <= s.due;
          position_sustain <= s.sustain;
          position_sostenuto <= s.sostenuto;
          position_soft_pedal <= s.soft_pedal;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check in order, stall on a pattern of its own
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        events_t want;
        results_seen++;
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected item", event_sustain, 0);
        end else begin
          want = pending_events.pop_front();
          if (event_sustain !== want.sustain)
            report_mismatch("event_sustain", event_sustain, want.sustain);
          if (event_sostenuto !== want.sostenuto)
            report_mismatch("event_sostenuto", event_sostenuto, want.sostenuto);
          if (event_soft_pedal !== want.soft_pedal)
            report_mismatch("event_soft_pedal", event_soft_pedal, want.soft_pedal);
        end
      end
      if (results_seen >= next_hold_at) begin
        hold_left = 80;
        next_hold_at += 850;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD_FRACTION) frac_q = val;
    else if (idx == CFG_INITIAL_THRESHOLD) init_q = val;
  endtask

  task automatic push_sample(logic due, logic [PB-1:0] a, logic [PB-1:0] b,
                             logic [PB-1:0] c);
    sample_q.push_back('{due, a, b, c});
  endtask

  task automatic settle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (LATENCY_SLACK) @(negedge clk);
  endtask

  function automatic logic [PB-1:0] clamp(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[PB-1:0];
  endfunction

  // half random pedal motion, some values around the live levels, some jumps and noise
  task automatic push_random(int count);
    sample_t s;
    logic [PB-1:0] v [PEDAL_COUNT];
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      for (int p = 0; p < PEDAL_COUNT; p++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          walk[p] = clamp(walk[p] + $urandom_range(0, 12000) - 6000);
        else if (pick < 62)
          walk[p] = clamp(int'(init_q) + $urandom_range(0, 2) - 1);
        else if (pick < 72)
          walk[p] = clamp(int'((longint'(65535) * longint'(frac_q)) >>> 16) +
                          $urandom_range(0, 4) - 2);
        else if (pick < 80)
          walk[p] = $urandom_range(0, 1) ? 65535 : 0;
        else
          walk[p] = $urandom_range(0, 65535);
        v[p] = walk[p][PB-1:0];
      end
      s.due = ($urandom_range(0, 9) != 0);
      s.sustain = v[PEDAL_SUSTAIN];
      s.sostenuto = v[PEDAL_SOSTENUTO];
      s.soft_pedal = v[PEDAL_SOFT];
      sample_q.push_back(s);
      made++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_THRESHOLD_FRACTION, RESET_FRACTION);
    write_reg(CFG_INITIAL_THRESHOLD, RESET_INITIAL);
    @(negedge clk);

    // not yet connected, level equal to the detect level, then connect
    push_sample(1'b0, 16'd1000, 16'd2000, 16'd3000);
    push_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(1'b1, 16'd13107, 16'd13107, 16'd13107);
    push_sample(1'b1, 16'hFFFF, 16'd13106, 16'd13107);
    // calibrating presses and releases through the running level
    push_sample(1'b1, 16'd0, 16'hFFFF, 16'd0);
    push_sample(1'b1, 16'hFFFF, 16'd32767, 16'd13108);
    push_sample(1'b0, 16'd0, 16'd0, 16'd0);
    push_sample(1'b1, 16'd32768, 16'd32768, 16'd6554);
    push_sample(1'b1, 16'd32767, 16'd32766, 16'd6553);
    push_sample(1'b1, 16'd0, 16'd0, 16'd0);
    push_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(1'b1, 16'hAAAA, 16'h5555, 16'h8000);
    settle();

    write_reg(CFG_THRESHOLD_FRACTION, 16'h0000);
    write_reg(CFG_INITIAL_THRESHOLD, 16'h0000);
    write_reg(CFG_SPARE_LO, 16'h1234);
    @(negedge clk);
    push_sample(1'b1, 16'd0, 16'd1, 16'hFFFF);
    push_sample(1'b1, 16'd1, 16'd0, 16'd0);
    push_sample(1'b1, 16'd0, 16'd0, 16'd1);
    push_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle();

    write_reg(CFG_THRESHOLD_FRACTION, 16'hFFFF);
    write_reg(CFG_INITIAL_THRESHOLD, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    @(negedge clk);
    push_sample(1'b1, 16'hFFFF, 16'hFFFE, 16'd0);
    push_sample(1'b1, 16'hFFFE, 16'hFFFF, 16'hFFFF);
    push_sample(1'b1, 16'd0, 16'd0, 16'hFFFE);
    push_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_THRESHOLD_FRACTION, REG_BITS'($urandom_range(0, 65535)));
          write_reg(CFG_INITIAL_THRESHOLD, REG_BITS'($urandom_range(0, 65535)));
        end
        1: begin
          write_reg(CFG_THRESHOLD_FRACTION, 16'hFFFF);
          write_reg(CFG_INITIAL_THRESHOLD, 16'h0000);
        end
        2: begin
          write_reg(CFG_THRESHOLD_FRACTION, 16'h0000);
          write_reg(CFG_INITIAL_THRESHOLD, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_THRESHOLD_FRACTION, RESET_FRACTION);
          write_reg(CFG_INITIAL_THRESHOLD, RESET_INITIAL);
        end
        4: begin
          write_reg(CFG_THRESHOLD_FRACTION, REG_BITS'($urandom_range(1, 65535)));
          write_reg(CFG_INITIAL_THRESHOLD, REG_BITS'($urandom_range(0, 20000)));
          write_reg(CFG_SPARE_LO, REG_BITS'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(CFG_THRESHOLD_FRACTION, 16'h0001);
          write_reg(CFG_INITIAL_THRESHOLD, REG_BITS'($urandom_range(0, 65535)));
        end
      endcase
      @(negedge clk);
      push_random(290);
      settle();
    end

    if (mismatches == 0 && pending_events.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
